FILE: rtl/blpg_pkg.sv
// shared types and constants of the bresenham line pixel generator
`default_nettype none
package blpg_pkg;

   localparam int COORD_BITS     = 12;
   localparam int FRAME_BITS     = 12;
   localparam int COLOR_BITS     = 24;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int ERR_BITS       = COORD_BITS + 3;
   localparam int INCS_BITS      = COORD_BITS + 2;
   localparam int CMP_BITS       = (COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = FRAME_BITS'(640);
   localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = FRAME_BITS'(480);

   // byte address bit that selects the register
   localparam int CSR_INDEX_BIT = 2;

   localparam logic CMD_NEW_LINE = 1'b0;
   localparam logic CMD_STEP     = 1'b1;

   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] width;
      logic [FRAME_BITS-1:0] height;
   } frame_cfg_type;

   // classified item handed from the front to the back
   typedef struct packed {
      logic                         is_line;
      logic                         steep;
      logic                         minor_down;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_major;
      logic        [COORD_BITS-1:0] dmaj;
      logic        [COORD_BITS-1:0] dmin;
      logic        [COLOR_BITS-1:0] color;
   } line_cmd_type;

endpackage
`default_nettype wire

FILE: rtl/bresenham_line_pixel_generator_unit.sv
// top level of the bresenham line pixel generator: csr block, front, queue and back
// a request passes the front register, the queue and the result register in turn
// throughput: one item per cycle while the result is not stalled, set by the single
//   error-term add and major-axis compare in the back stage; a step with no line in progress gives no result
// reset: synchronous, active high; clears the queue, line state and result valid,
//   and loads frame width 640 and frame height 480
`default_nettype none
module bresenham_line_pixel_generator_unit (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic                                    req_cmd,
   input  wire logic signed [blpg_pkg::COORD_BITS-1:0]  req_start_x,
   input  wire logic signed [blpg_pkg::COORD_BITS-1:0]  req_start_y,
   input  wire logic signed [blpg_pkg::COORD_BITS-1:0]  req_end_x,
   input  wire logic signed [blpg_pkg::COORD_BITS-1:0]  req_end_y,
   input  wire logic        [blpg_pkg::COLOR_BITS-1:0]  req_color,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic signed [blpg_pkg::COORD_BITS-1:0]       rsp_pix_x,
   output logic signed [blpg_pkg::COORD_BITS-1:0]       rsp_pix_y,
   output logic        [blpg_pkg::COLOR_BITS-1:0]       rsp_pix_color,
   output logic                                         rsp_write_enable,
   output logic                                         rsp_last_pixel,
   input  wire logic                                    csr_psel,
   input  wire logic                                    csr_penable,
   input  wire logic                                    csr_pwrite,
   input  wire logic [blpg_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  wire logic [blpg_pkg::CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [blpg_pkg::CSR_DATA_BITS-1:0]           csr_prdata,
   output logic                                         csr_pready
);

   localparam int FB = blpg_pkg::FRAME_BITS;

   logic [FB-1:0]           frame_width_ff, frame_width_in;
   logic [FB-1:0]           frame_height_ff, frame_height_in;
   logic                    csr_write;
   blpg_pkg::reg_index_type csr_index;
   blpg_pkg::frame_cfg_type frame_cfg;

   logic                   push_valid;
   logic                   push_ready;
   blpg_pkg::line_cmd_type push_cmd;
   logic                   pop_valid;
   logic                   pop_ready;
   blpg_pkg::line_cmd_type pop_cmd;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = blpg_pkg::reg_index_type'(csr_paddr[blpg_pkg::CSR_INDEX_BIT]);

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         case (csr_index)
            blpg_pkg::REG_FRAME_WIDTH: begin
               frame_width_in = csr_pwdata[FB-1:0];
            end
            blpg_pkg::REG_FRAME_HEIGHT: begin
               frame_height_in = csr_pwdata[FB-1:0];
            end
            default: begin
               frame_width_in = frame_width_ff;
            end
         endcase
      end
      case (csr_index)
         blpg_pkg::REG_FRAME_WIDTH: begin
            csr_prdata = blpg_pkg::CSR_DATA_BITS'(frame_width_ff);
         end
         blpg_pkg::REG_FRAME_HEIGHT: begin
            csr_prdata = blpg_pkg::CSR_DATA_BITS'(frame_height_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= blpg_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= blpg_pkg::FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   assign frame_cfg.width  = frame_width_ff;
   assign frame_cfg.height = frame_height_ff;

   blpg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .req_color   (req_color),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   blpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   blpg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_cmd          (pop_cmd),
      .frame_cfg        (frame_cfg),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pix_x        (rsp_pix_x),
      .rsp_pix_y        (rsp_pix_y),
      .rsp_pix_color    (rsp_pix_color),
      .rsp_write_enable (rsp_write_enable),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule
`default_nettype wire

FILE: rtl/blpg_front.sv
// front stage: takes items, computes deltas, octant group and endpoint order
`default_nettype none
module blpg_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_cmd,
   input  wire logic signed [blpg_pkg::COORD_BITS-1:0] req_start_x,
   input  wire logic signed [blpg_pkg::COORD_BITS-1:0] req_start_y,
   input  wire logic signed [blpg_pkg::COORD_BITS-1:0] req_end_x,
   input  wire logic signed [blpg_pkg::COORD_BITS-1:0] req_end_y,
   input  wire logic        [blpg_pkg::COLOR_BITS-1:0] req_color,
   output logic                                      push_valid,
   input  wire logic                                 push_ready,
   output blpg_pkg::line_cmd_type                    push_cmd
);

   localparam int C = blpg_pkg::COORD_BITS;

   logic                   stage_valid_ff;
   logic                   stage_valid_in;
   blpg_pkg::line_cmd_type stage_cmd_ff;
   blpg_pkg::line_cmd_type stage_cmd_in;

   logic signed [C:0] dxp;
   logic signed [C:0] dyp;
   logic        [C:0] dx_abs;
   logic        [C:0] dy_abs;
   logic [C-1:0]      dx;
   logic [C-1:0]      dy;
   logic              x_neg;
   logic              x_pos;
   logic              y_neg;
   logic              y_pos;
   logic              steep;
   logic              swap;
   logic              accept;

   assign req_ready = !stage_valid_ff || push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      dxp    = {req_end_x[C-1], req_end_x} - {req_start_x[C-1], req_start_x};
      dyp    = {req_end_y[C-1], req_end_y} - {req_start_y[C-1], req_start_y};
      dx_abs = dxp[C] ? $unsigned(-dxp) : $unsigned(dxp);
      dy_abs = dyp[C] ? $unsigned(-dyp) : $unsigned(dyp);
      dx     = dx_abs[C-1:0];
      dy     = dy_abs[C-1:0];
      x_neg  = dxp[C];
      x_pos  = !dxp[C] && (dxp != '0);
      y_neg  = dyp[C];
      y_pos  = !dyp[C] && (dyp != '0);
      steep  = dy > dx;

      stage_cmd_in         = stage_cmd_ff;
      stage_cmd_in.is_line = (req_cmd == blpg_pkg::CMD_NEW_LINE);
      stage_cmd_in.steep   = steep;
      stage_cmd_in.color   = req_color;
      if (steep) begin
         // walk upward in y
         swap                    = y_neg;
         stage_cmd_in.minor_down = swap ? x_pos : x_neg;
         stage_cmd_in.end_major  = swap ? req_start_y : req_end_y;
         stage_cmd_in.dmaj       = dy;
         stage_cmd_in.dmin       = dx;
      end else begin
         swap                    = x_neg;
         stage_cmd_in.minor_down = swap ? y_pos : y_neg;
         stage_cmd_in.end_major  = swap ? req_start_x : req_end_x;
         stage_cmd_in.dmaj       = dx;
         stage_cmd_in.dmin       = dy;
      end
      stage_cmd_in.start_x = swap ? req_end_x : req_start_x;
      stage_cmd_in.start_y = swap ? req_end_y : req_start_y;

      stage_valid_in = req_ready ? req_valid : stage_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (accept) begin
         stage_cmd_ff <= stage_cmd_in;
      end
   end

   assign push_valid = stage_valid_ff;
   assign push_cmd   = stage_cmd_ff;

endmodule
`default_nettype wire

FILE: rtl/blpg_queue.sv
// short queue of classified items between front and back
`default_nettype none
module blpg_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   output logic                        push_ready,
   input  wire blpg_pkg::line_cmd_type push_cmd,
   output logic                        pop_valid,
   input  wire logic                   pop_ready,
   output blpg_pkg::line_cmd_type      pop_cmd
);

   localparam int PB = blpg_pkg::QUEUE_PTR_BITS;
   localparam int CB = blpg_pkg::QUEUE_CNT_BITS;

   blpg_pkg::line_cmd_type entry_ff [blpg_pkg::QUEUE_DEPTH];
   logic [PB-1:0] wr_ptr_ff;
   logic [PB-1:0] wr_ptr_in;
   logic [PB-1:0] rd_ptr_ff;
   logic [PB-1:0] rd_ptr_in;
   logic [CB-1:0] count_ff;
   logic [CB-1:0] count_in;
   logic          push;
   logic          pop;

   assign push_ready = (count_ff != CB'(blpg_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PB'(blpg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PB'(blpg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/blpg_back.sv
// back stage: line state, error term stepping, frame check and result register
`default_nettype none
module blpg_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 pop_valid,
   output logic                                      pop_ready,
   input  wire blpg_pkg::line_cmd_type               pop_cmd,
   input  wire blpg_pkg::frame_cfg_type              frame_cfg,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [blpg_pkg::COORD_BITS-1:0]    rsp_pix_x,
   output logic signed [blpg_pkg::COORD_BITS-1:0]    rsp_pix_y,
   output logic        [blpg_pkg::COLOR_BITS-1:0]    rsp_pix_color,
   output logic                                      rsp_write_enable,
   output logic                                      rsp_last_pixel
);

   localparam int C  = blpg_pkg::COORD_BITS;
   localparam int E  = blpg_pkg::ERR_BITS;
   localparam int S  = blpg_pkg::INCS_BITS;
   localparam int CM = blpg_pkg::CMP_BITS;

   // line state
   logic signed [C-1:0] cur_x_ff, cur_x_in;
   logic signed [C-1:0] cur_y_ff, cur_y_in;
   logic signed [C-1:0] end_major_ff, end_major_in;
   logic signed [E-1:0] err_ff, err_in;
   logic        [S-1:0] inc_s_ff, inc_s_in;
   logic signed [E-1:0] inc_d_ff, inc_d_in;
   logic                steep_ff, steep_in;
   logic                minor_down_ff, minor_down_in;
   logic                active_ff, active_in;
   logic [blpg_pkg::COLOR_BITS-1:0] color_ff, color_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [C-1:0] pix_x_ff;
   logic signed [C-1:0] pix_y_ff;
   logic [blpg_pkg::COLOR_BITS-1:0] pix_color_ff;
   logic                we_ff;
   logic                last_ff;

   logic                out_free;
   logic                emits;
   logic                take;
   logic                fire;
   logic                diag;
   logic signed [C-1:0] major_cur;
   logic signed [C-1:0] minor_cur;
   logic signed [C-1:0] major_nx;
   logic signed [C-1:0] minor_nx;
   logic signed [C-1:0] nx;
   logic signed [C-1:0] ny;
   logic                last_w;
   logic                in_x;
   logic                in_y;
   logic signed [E-1:0] dmin2;
   logic signed [E-1:0] dmaj1;
   logic signed [E-1:0] dmaj2;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emits     = pop_cmd.is_line || active_ff;
   // a step with no line in progress drains without a result
   assign pop_ready = out_free || !emits;
   assign take      = pop_valid && pop_ready;
   assign fire      = take && emits;

   always_comb begin
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      end_major_in  = end_major_ff;
      err_in        = err_ff;
      inc_s_in      = inc_s_ff;
      inc_d_in      = inc_d_ff;
      steep_in      = steep_ff;
      minor_down_in = minor_down_ff;
      active_in     = active_ff;
      color_in      = color_ff;

      dmin2 = {2'b00, pop_cmd.dmin, 1'b0};
      dmaj1 = {3'b000, pop_cmd.dmaj};
      dmaj2 = {2'b00, pop_cmd.dmaj, 1'b0};

      diag      = !err_ff[E-1] && (err_ff != '0);
      major_cur = steep_ff ? cur_y_ff : cur_x_ff;
      minor_cur = steep_ff ? cur_x_ff : cur_y_ff;
      major_nx  = major_cur + C'(1);
      if (!diag) begin
         minor_nx = minor_cur;
      end else if (minor_down_ff) begin
         minor_nx = minor_cur - C'(1);
      end else begin
         minor_nx = minor_cur + C'(1);
      end

      if (pop_cmd.is_line) begin
         nx     = pop_cmd.start_x;
         ny     = pop_cmd.start_y;
         last_w = (pop_cmd.dmaj == '0);
      end else begin
         nx     = steep_ff ? minor_nx : major_nx;
         ny     = steep_ff ? major_nx : minor_nx;
         last_w = (major_nx >= end_major_ff);
      end

      if (take && pop_cmd.is_line) begin
         cur_x_in      = pop_cmd.start_x;
         cur_y_in      = pop_cmd.start_y;
         end_major_in  = pop_cmd.end_major;
         err_in        = dmin2 - dmaj1;
         inc_s_in      = {1'b0, pop_cmd.dmin, 1'b0};
         inc_d_in      = dmin2 - dmaj2;
         steep_in      = pop_cmd.steep;
         minor_down_in = pop_cmd.minor_down;
         active_in     = !last_w;
         color_in      = pop_cmd.color;
      end else if (take && active_ff) begin
         cur_x_in  = nx;
         cur_y_in  = ny;
         err_in    = err_ff + (diag ? inc_d_ff : $signed({1'b0, inc_s_ff}));
         active_in = !last_w;
      end

      // frame check accepts coordinate 0
      in_x = !nx[C-1] && (CM'($unsigned(nx)) < CM'(frame_cfg.width));
      in_y = !ny[C-1] && (CM'($unsigned(ny)) < CM'(frame_cfg.height));

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         end_major_ff  <= '0;
         err_ff        <= '0;
         inc_s_ff      <= '0;
         inc_d_ff      <= '0;
         steep_ff      <= 1'b0;
         minor_down_ff <= 1'b0;
         active_ff     <= 1'b0;
         color_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         end_major_ff  <= end_major_in;
         err_ff        <= err_in;
         inc_s_ff      <= inc_s_in;
         inc_d_ff      <= inc_d_in;
         steep_ff      <= steep_in;
         minor_down_ff <= minor_down_in;
         active_ff     <= active_in;
         color_ff      <= color_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (fire) begin
         pix_x_ff     <= nx;
         pix_y_ff     <= ny;
         pix_color_ff <= pop_cmd.is_line ? pop_cmd.color : color_ff;
         we_ff        <= in_x && in_y;
         last_ff      <= last_w;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pix_x        = pix_x_ff;
   assign rsp_pix_y        = pix_y_ff;
   assign rsp_pix_color    = pix_color_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_last_pixel   = last_ff;

endmodule
`default_nettype wire

FILE: rtl/blpg_checker.sv
// port-level checks of the bresenham line pixel generator, bound to the top level
`default_nettype none
module blpg_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_ready,
   input wire logic signed [blpg_pkg::COORD_BITS-1:0] rsp_pix_x,
   input wire logic signed [blpg_pkg::COORD_BITS-1:0] rsp_pix_y,
   input wire logic        [blpg_pkg::COLOR_BITS-1:0] rsp_pix_color,
   input wire logic                                   rsp_write_enable,
   input wire logic                                   rsp_last_pixel
);

   localparam int C = blpg_pkg::COORD_BITS;

   // no result survives a reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a pixel with a negative coordinate is never written
   a_we_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_enable |-> !rsp_pix_x[C-1] && !rsp_pix_y[C-1])
      else $error("write enable on negative coordinate");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pix_x) && $stable(rsp_pix_y)
         && $stable(rsp_pix_color) && $stable(rsp_write_enable)
         && $stable(rsp_last_pixel))
      else $error("result changed while stalled");

endmodule

bind bresenham_line_pixel_generator_unit blpg_checker u_blpg_checker (.*);
`default_nettype wire
